// ----- design/rs_10_8_erasure_codec_top_assert.svh -----
// ----------------------------------------------------------------------------
// RS(10,8) erasure codec assertion macros
// Shared concurrent check forms; clk and arst_n are taken from the using scope.
// ----------------------------------------------------------------------------
`ifndef RS_10_8_ERASURE_CODEC_TOP_ASSERT_SVH
`define RS_10_8_ERASURE_CODEC_TOP_ASSERT_SVH

// same-cycle implication
`define RSEC_CHECK(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rsec check failed");

// next-cycle implication
`define RSEC_CHECK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rsec next-cycle check failed");

`endif

// ----- design/rsec_pkg.sv -----
// ----------------------------------------------------------------------------
// rsec_pkg
// Types, codes and GF(256) helpers for the RS(10,8) erasure codec.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsec_pkg;

	localparam int NUM_DATA = 8;
	localparam int BYTE_W   = 8;
	localparam int DATA_W   = NUM_DATA * BYTE_W;
	localparam int MASK_W   = 10;
	localparam int IDX_W    = 3;

	// field polynomial 0x11D, low byte only
	localparam logic [7:0] POLY_LOW = 8'h1D;
	localparam logic [7:0] INV_EXP  = 8'd254;
	localparam logic [7:0] GEN      = 8'd2;

	typedef logic [7:0] gf_t;
	typedef gf_t coef_tbl_t [NUM_DATA];
	typedef gf_t k_tbl_t [NUM_DATA * NUM_DATA];

	typedef enum logic {
		CMD_ENCODE  = 1'b0,
		CMD_RECOVER = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_TOO_MANY  = 2'd1,
		STATUS_NO_PARITY = 2'd2
	} status_t;

	// per-column control carried down the pipe
	typedef struct packed {
		status_t              status;
		logic                 recalc;   // recompute both parities from data
		logic                 fix_a;    // overwrite byte idx_a with solved value
		logic                 fix_b;    // overwrite byte idx_b with s0 ^ value
		logic                 use_p0;   // single erasure rebuilt from XOR parity
		logic [IDX_W-1:0]     idx_a;
		logic [IDX_W-1:0]     idx_b;
		logic [NUM_DATA-1:0]  keep;     // data bytes that enter the syndromes
	} ctrl_t;

	function automatic gf_t gf_mul(gf_t a_in, gf_t b_in);
		gf_t a;
		gf_t b;
		gf_t p;
		a = a_in;
		b = b_in;
		p = '0;
		for (int k = 0; k < 8; k++) begin
			if (b[0])
				p = p ^ a;
			if (a[7])
				a = {a[6:0], 1'b0} ^ POLY_LOW;
			else
				a = {a[6:0], 1'b0};
			b = {1'b0, b[7:1]};
		end
		return p;
	endfunction

	function automatic gf_t gf_pow(gf_t base_in, logic [7:0] e_in);
		gf_t r;
		gf_t base;
		r = 8'd1;
		base = base_in;
		for (int k = 0; k < 8; k++) begin
			if (e_in[k])
				r = gf_mul(r, base);
			base = gf_mul(base, base);
		end
		return r;
	endfunction

	function automatic gf_t gf_inv(gf_t v);
		return (v == '0) ? '0 : gf_pow(v, INV_EXP);
	endfunction

	function automatic coef_tbl_t build_coef_tbl();
		coef_tbl_t t;
		for (int i = 0; i < NUM_DATA; i++)
			t[i] = gf_pow(GEN, 8'(i));
		return t;
	endfunction

	localparam coef_tbl_t COEF_TBL = build_coef_tbl();

	// index {a,b}: a == b gives 1/coef(a), else 1/(coef(a) ^ coef(b))
	function automatic k_tbl_t build_k_tbl();
		k_tbl_t t;
		for (int a = 0; a < NUM_DATA; a++) begin
			for (int b = 0; b < NUM_DATA; b++) begin
				if (a == b)
					t[a * NUM_DATA + b] = gf_inv(gf_pow(GEN, 8'(a)));
				else
					t[a * NUM_DATA + b] = gf_inv(gf_pow(GEN, 8'(a)) ^ gf_pow(GEN, 8'(b)));
			end
		end
		return t;
	endfunction

	localparam k_tbl_t K_TBL = build_k_tbl();

endpackage

// ----- design/rsec_decode.sv -----
// ----------------------------------------------------------------------------
// rsec_decode
// Stage 1: erasure count, erased index pick, status and column control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsec_decode
	import rsec_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic [DATA_W-1:0] data_bytes,
	input  logic [7:0]        parity_zero,
	input  logic [7:0]        parity_one,
	input  logic [MASK_W-1:0] present_mask,
	input  logic              last_column,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] out_data,
	output logic [7:0]        out_p0,
	output logic [7:0]        out_p1,
	output logic              out_last,
	output ctrl_t             out_ctrl
);

	logic              valid_s1;
	logic [DATA_W-1:0] data_s1;
	logic [7:0]        p0_s1;
	logic [7:0]        p1_s1;
	logic              last_s1;
	ctrl_t             ctrl_s1;

	logic [3:0]        miss;
	logic [3:0]        mdata;
	logic [IDX_W-1:0]  idx_a;
	logic [IDX_W-1:0]  idx_b;
	logic              has_p0;
	logic              has_p1;
	ctrl_t             ctrl_d;

	always_comb begin
		miss  = '0;
		mdata = '0;
		for (int i = 0; i < MASK_W; i++)
			miss = miss + {3'b000, ~present_mask[i]};
		for (int i = 0; i < NUM_DATA; i++)
			mdata = mdata + {3'b000, ~present_mask[i]};
		// lowest erased data shard
		idx_a = '0;
		for (int i = NUM_DATA - 1; i >= 0; i--)
			if (!present_mask[i])
				idx_a = IDX_W'(i);
		// next erased one above it, or idx_a when there is none
		idx_b = idx_a;
		for (int i = NUM_DATA - 1; i >= 0; i--)
			if (!present_mask[i] && (IDX_W'(i) > idx_a))
				idx_b = IDX_W'(i);
	end

	assign has_p0 = present_mask[NUM_DATA];
	assign has_p1 = present_mask[NUM_DATA + 1];

	always_comb begin
		ctrl_d        = '0;
		ctrl_d.status = STATUS_OK;
		ctrl_d.idx_a  = idx_a;
		ctrl_d.idx_b  = idx_b;
		ctrl_d.keep   = present_mask[NUM_DATA-1:0];
		if (cmd == CMD_ENCODE) begin
			ctrl_d.recalc = 1'b1;
			ctrl_d.keep   = '1;
		end else if (miss > 4'd2) begin
			ctrl_d.status = STATUS_TOO_MANY;
		end else if (miss == 4'd0) begin
			ctrl_d.recalc = 1'b0;
		end else if (mdata == 4'd0) begin
			ctrl_d.recalc = 1'b1;
		end else if (mdata == 4'd1) begin
			if (has_p0) begin
				ctrl_d.fix_a  = 1'b1;
				ctrl_d.use_p0 = 1'b1;
				ctrl_d.recalc = 1'b1;
			end else if (has_p1) begin
				ctrl_d.fix_a  = 1'b1;
				ctrl_d.recalc = 1'b1;
			end else begin
				ctrl_d.status = STATUS_NO_PARITY;
			end
		end else begin
			if (!has_p0 || !has_p1) begin
				ctrl_d.status = STATUS_NO_PARITY;
			end else begin
				ctrl_d.fix_a = 1'b1;
				ctrl_d.fix_b = 1'b1;
			end
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_bytes;
			p0_s1   <= parity_zero;
			p1_s1   <= parity_one;
			last_s1 <= last_column;
			ctrl_s1 <= ctrl_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;
	assign out_p0    = p0_s1;
	assign out_p1    = p1_s1;
	assign out_last  = last_s1;
	assign out_ctrl  = ctrl_s1;

endmodule

// ----- design/rsec_syndrome.sv -----
// ----------------------------------------------------------------------------
// rsec_syndrome
// Stage 2: partial syndromes over surviving bytes, solve constants lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsec_syndrome
	import rsec_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DATA_W-1:0] in_data,
	input  logic [7:0]        in_p0,
	input  logic [7:0]        in_p1,
	input  logic              in_last,
	input  ctrl_t             in_ctrl,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] out_data,
	output logic [7:0]        out_p0,
	output logic [7:0]        out_p1,
	output logic              out_last,
	output ctrl_t             out_ctrl,
	output gf_t               out_syn0,
	output gf_t               out_syn1,
	output gf_t               out_k,
	output gf_t               out_cb
);

	logic              valid_s2;
	logic [DATA_W-1:0] data_s2;
	logic [7:0]        p0_s2;
	logic [7:0]        p1_s2;
	logic              last_s2;
	ctrl_t             ctrl_s2;
	gf_t               syn0_s2;
	gf_t               syn1_s2;
	gf_t               k_s2;
	gf_t               cb_s2;

	gf_t syn0_d;
	gf_t syn1_d;
	gf_t k_d;
	gf_t cb_d;

	always_comb begin
		syn0_d = in_p0;
		syn1_d = in_p1;
		for (int i = 0; i < NUM_DATA; i++) begin
			if (in_ctrl.keep[i]) begin
				syn0_d = syn0_d ^ in_data[BYTE_W*i +: BYTE_W];
				syn1_d = syn1_d ^ gf_mul(COEF_TBL[i], in_data[BYTE_W*i +: BYTE_W]);
			end
		end
	end

	assign k_d  = in_ctrl.use_p0 ? 8'd1 : K_TBL[{in_ctrl.idx_a, in_ctrl.idx_b}];
	assign cb_d = in_ctrl.fix_b ? COEF_TBL[in_ctrl.idx_b] : 8'd0;

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (in_ready)
			valid_s2 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2 <= in_data;
			p0_s2   <= in_p0;
			p1_s2   <= in_p1;
			last_s2 <= in_last;
			ctrl_s2 <= in_ctrl;
			syn0_s2 <= syn0_d;
			syn1_s2 <= syn1_d;
			k_s2    <= k_d;
			cb_s2   <= cb_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;
	assign out_p0    = p0_s2;
	assign out_p1    = p1_s2;
	assign out_last  = last_s2;
	assign out_ctrl  = ctrl_s2;
	assign out_syn0  = syn0_s2;
	assign out_syn1  = syn1_s2;
	assign out_k     = k_s2;
	assign out_cb    = cb_s2;

endmodule

// ----- design/rsec_solve.sv -----
// ----------------------------------------------------------------------------
// rsec_solve
// Stages 3 and 4: two GF(256) multiplies, one per stage, give the value of
// the lowest erased data byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsec_solve
	import rsec_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DATA_W-1:0] in_data,
	input  logic [7:0]        in_p0,
	input  logic [7:0]        in_p1,
	input  logic              in_last,
	input  ctrl_t             in_ctrl,
	input  gf_t               in_syn0,
	input  gf_t               in_syn1,
	input  gf_t               in_k,
	input  gf_t               in_cb,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] out_data,
	output logic [7:0]        out_p0,
	output logic [7:0]        out_p1,
	output logic              out_last,
	output ctrl_t             out_ctrl,
	output gf_t               out_syn0,
	output gf_t               out_val
);

	// stage 3
	logic              valid_s3;
	logic              ready_s3;
	logic [DATA_W-1:0] data_s3;
	logic [7:0]        p0_s3;
	logic [7:0]        p1_s3;
	logic              last_s3;
	ctrl_t             ctrl_s3;
	gf_t               syn0_s3;
	gf_t               k_s3;
	gf_t               t_s3;
	gf_t               t_d;

	// stage 4
	logic              valid_s4;
	logic              ready_s4;
	logic [DATA_W-1:0] data_s4;
	logic [7:0]        p0_s4;
	logic [7:0]        p1_s4;
	logic              last_s4;
	ctrl_t             ctrl_s4;
	gf_t               syn0_s4;
	gf_t               val_s4;

	// t = s1 ^ coef(b)*s0 (cb is zero for one erasure); XOR parity path takes s0
	assign t_d = in_ctrl.use_p0 ? in_syn0 : (in_syn1 ^ gf_mul(in_cb, in_syn0));

	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s4 = !valid_s4 || out_ready;
	assign in_ready = ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s3)
				valid_s3 <= in_valid;
			if (ready_s4)
				valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && in_valid) begin
			data_s3 <= in_data;
			p0_s3   <= in_p0;
			p1_s3   <= in_p1;
			last_s3 <= in_last;
			ctrl_s3 <= in_ctrl;
			syn0_s3 <= in_syn0;
			k_s3    <= in_k;
			t_s3    <= t_d;
		end
		if (ready_s4 && valid_s3) begin
			data_s4 <= data_s3;
			p0_s4   <= p0_s3;
			p1_s4   <= p1_s3;
			last_s4 <= last_s3;
			ctrl_s4 <= ctrl_s3;
			syn0_s4 <= syn0_s3;
			val_s4  <= gf_mul(k_s3, t_s3);
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = data_s4;
	assign out_p0    = p0_s4;
	assign out_p1    = p1_s4;
	assign out_last  = last_s4;
	assign out_ctrl  = ctrl_s4;
	assign out_syn0  = syn0_s4;
	assign out_val   = val_s4;

endmodule

// ----- design/rsec_rebuild.sv -----
// ----------------------------------------------------------------------------
// rsec_rebuild
// Stage 5: patch erased bytes, recompute parities where asked, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rs_10_8_erasure_codec_top_assert.svh"

module rsec_rebuild
	import rsec_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DATA_W-1:0] in_data,
	input  logic [7:0]        in_p0,
	input  logic [7:0]        in_p1,
	input  logic              in_last,
	input  ctrl_t             in_ctrl,
	input  gf_t               in_syn0,
	input  gf_t               in_val,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] data_out,
	output logic [7:0]        parity_zero_out,
	output logic [7:0]        parity_one_out,
	output logic [1:0]        status,
	output logic              last_out
);

	logic              valid_s5;
	logic [DATA_W-1:0] data_s5;
	logic [7:0]        p0_s5;
	logic [7:0]        p1_s5;
	status_t           status_s5;
	logic              last_s5;
	logic              recalc_s5;

	logic [DATA_W-1:0] fixed_d;
	gf_t               pc0_d;
	gf_t               pc1_d;
	gf_t               chk_p0;

	always_comb begin
		fixed_d = in_data;
		for (int i = 0; i < NUM_DATA; i++) begin
			if (in_ctrl.fix_a && (in_ctrl.idx_a == IDX_W'(i)))
				fixed_d[BYTE_W*i +: BYTE_W] = in_val;
			if (in_ctrl.fix_b && (in_ctrl.idx_b == IDX_W'(i)))
				fixed_d[BYTE_W*i +: BYTE_W] = in_syn0 ^ in_val;
		end
		pc0_d = '0;
		pc1_d = '0;
		for (int i = 0; i < NUM_DATA; i++) begin
			pc0_d = pc0_d ^ fixed_d[BYTE_W*i +: BYTE_W];
			pc1_d = pc1_d ^ gf_mul(COEF_TBL[i], fixed_d[BYTE_W*i +: BYTE_W]);
		end
	end

	assign in_ready = !valid_s5 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s5 <= 1'b0;
		else if (in_ready)
			valid_s5 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s5   <= fixed_d;
			p0_s5     <= in_ctrl.recalc ? pc0_d : in_p0;
			p1_s5     <= in_ctrl.recalc ? pc1_d : in_p1;
			status_s5 <= in_ctrl.status;
			last_s5   <= in_last;
			recalc_s5 <= in_ctrl.recalc;
		end
	end

	assign out_valid       = valid_s5;
	assign data_out        = data_s5;
	assign parity_zero_out = p0_s5;
	assign parity_one_out  = p1_s5;
	assign status          = status_s5;
	assign last_out        = last_s5;

	always_comb begin
		chk_p0 = '0;
		for (int i = 0; i < NUM_DATA; i++)
			chk_p0 = chk_p0 ^ data_s5[BYTE_W*i +: BYTE_W];
	end

	`RSEC_CHECK(a_err_no_touch, in_valid && (in_ctrl.status != STATUS_OK), !in_ctrl.fix_a && !in_ctrl.fix_b && !in_ctrl.recalc)
	`RSEC_CHECK(a_two_fix_order, in_valid && in_ctrl.fix_b, in_ctrl.fix_a && (in_ctrl.idx_a < in_ctrl.idx_b) && !in_ctrl.recalc)
	`RSEC_CHECK(a_recalc_p0, valid_s5 && recalc_s5, p0_s5 == chk_p0)
	`RSEC_CHECK_NEXT(a_err_data_pass, in_valid && in_ready && (in_ctrl.status != STATUS_OK), data_s5 == $past(in_data))

endmodule

// ----- design/rs_10_8_erasure_codec_top.sv -----
// ----------------------------------------------------------------------------
// rs_10_8_erasure_codec_top - RS(10,8) GF(256) erasure codec, one byte column
// Pipeline: five register stages; the first loads at the input transfer edge,
//           the fifth is the output register that presents the result.
// Throughput: one column per cycle unless out_ready stalls, paced stage by stage.
// Reset: arst_n clears all stage valid bits asynchronously; payload is not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rs_10_8_erasure_codec_top
	import rsec_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// input channel
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic [DATA_W-1:0] data_bytes,
	input  logic [7:0]        parity_zero,
	input  logic [7:0]        parity_one,
	input  logic [MASK_W-1:0] present_mask,
	input  logic              last_column,
	// result channel
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] data_out,
	output logic [7:0]        parity_zero_out,
	output logic [7:0]        parity_one_out,
	output logic [1:0]        status,
	output logic              last_out
);

	// Pipeline overview
	//   s1 decode   : count erasures, pick erased indices a < b, set status and
	//                 per-column control (which bytes to patch, parity recompute)
	//   s2 syndrome : s0 = p0 ^ XOR of surviving bytes, s1 = p1 ^ sum coef(i)*d[i]
	//                 over surviving bytes; look up k and coef(b)
	//   s3 solve    : t = s1 ^ coef(b)*s0   (t = s0 when XOR parity rebuilds)
	//   s4 solve    : v = k * t             (lowest erased byte)
	//   s5 rebuild  : d[a] = v, d[b] = s0 ^ v; recompute parities where asked
	// Every stage holds its own valid bit and advances when empty or when the
	// next stage moves, so bubbles close up under a stalled output and nothing
	// is dropped or repeated. The stage 5 register is the output register.

	logic              v1;
	logic              r1;
	logic [DATA_W-1:0] d1;
	logic [7:0]        p0_1;
	logic [7:0]        p1_1;
	logic              l1;
	ctrl_t             c1;

	logic              v2;
	logic              r2;
	logic [DATA_W-1:0] d2;
	logic [7:0]        p0_2;
	logic [7:0]        p1_2;
	logic              l2;
	ctrl_t             c2;
	gf_t               syn0_2;
	gf_t               syn1_2;
	gf_t               k_2;
	gf_t               cb_2;

	logic              v4;
	logic              r4;
	logic [DATA_W-1:0] d4;
	logic [7:0]        p0_4;
	logic [7:0]        p1_4;
	logic              l4;
	ctrl_t             c4;
	gf_t               syn0_4;
	gf_t               val_4;

	rsec_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.data_bytes   (data_bytes),
		.parity_zero  (parity_zero),
		.parity_one   (parity_one),
		.present_mask (present_mask),
		.last_column  (last_column),
		.out_valid    (v1),
		.out_ready    (r1),
		.out_data     (d1),
		.out_p0       (p0_1),
		.out_p1       (p1_1),
		.out_last     (l1),
		.out_ctrl     (c1)
	);

	rsec_syndrome u_syndrome (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r1),
		.in_data   (d1),
		.in_p0     (p0_1),
		.in_p1     (p1_1),
		.in_last   (l1),
		.in_ctrl   (c1),
		.out_valid (v2),
		.out_ready (r2),
		.out_data  (d2),
		.out_p0    (p0_2),
		.out_p1    (p1_2),
		.out_last  (l2),
		.out_ctrl  (c2),
		.out_syn0  (syn0_2),
		.out_syn1  (syn1_2),
		.out_k     (k_2),
		.out_cb    (cb_2)
	);

	rsec_solve u_solve (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v2),
		.in_ready  (r2),
		.in_data   (d2),
		.in_p0     (p0_2),
		.in_p1     (p1_2),
		.in_last   (l2),
		.in_ctrl   (c2),
		.in_syn0   (syn0_2),
		.in_syn1   (syn1_2),
		.in_k      (k_2),
		.in_cb     (cb_2),
		.out_valid (v4),
		.out_ready (r4),
		.out_data  (d4),
		.out_p0    (p0_4),
		.out_p1    (p1_4),
		.out_last  (l4),
		.out_ctrl  (c4),
		.out_syn0  (syn0_4),
		.out_val   (val_4)
	);

	// output register; while a result waits, earlier stages still fill empty slots
	rsec_rebuild u_rebuild (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (v4),
		.in_ready        (r4),
		.in_data         (d4),
		.in_p0           (p0_4),
		.in_p1           (p1_4),
		.in_last         (l4),
		.in_ctrl         (c4),
		.in_syn0         (syn0_4),
		.in_val          (val_4),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.data_out        (data_out),
		.parity_zero_out (parity_zero_out),
		.parity_one_out  (parity_one_out),
		.status          (status),
		.last_out        (last_out)
	);

endmodule
